>>> sv/msort_pkg.sv
// Shared constants, state encodings and the status type for the merge sort engine.
`default_nettype none

package msort_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int TDATA_W_DEF    = ((DATA_WIDTH_DEF + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EM_REQ,
    ST_EM_LOAD
  } top_state_t;

  typedef enum logic [1:0] {
    MG_IDLE,
    MG_RD,
    MG_WR
  } merge_state_t;

  typedef struct packed {
    logic done;
    logic result_sel;
  } merge_status_t;

endpackage

`default_nettype wire

>>> sv/msort_ram.sv
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr_a,
  input  wire logic [AW-1:0]    raddr_b,
  output logic      [WIDTH-1:0] rdata_a,
  output logic      [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> sv/msort_merge.sv
// Merge sequencer: bottom-up passes with one shared comparator, ping-ponging between two RAMs.
`default_nettype none

module msort_merge import msort_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int SW    = CNT_W + 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [CNT_W-1:0]      n,
  output logic      [AW-1:0]         rd_addr_a,
  output logic      [AW-1:0]         rd_addr_b,
  output logic                       src_sel,
  input  wire logic [DATA_WIDTH-1:0] rd_data_a,
  input  wire logic [DATA_WIDTH-1:0] rd_data_b,
  output logic                       wr_en,
  output logic                       wr_sel,
  output logic      [AW-1:0]         wr_addr,
  output logic      [DATA_WIDTH-1:0] wr_data,
  output merge_status_t              status
);

  merge_state_t     state_r, state_nxt;
  logic [CNT_W-1:0] a_r, a_nxt, b_r, b_nxt, k_r, k_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt, hi_r, hi_nxt, width_r, width_nxt;
  logic             src_r, src_nxt, done_r, done_nxt, sel_r, sel_nxt;
  logic             a_ok, b_ok, take_a;

  assign a_ok   = a_r < mid_r;
  assign b_ok   = b_r < hi_r;
  // Left run wins ties, which keeps the sort stable.
  assign take_a = a_ok && (!b_ok || ($signed(rd_data_a) <= $signed(rd_data_b)));

  assign rd_addr_a = a_r[AW-1:0];
  assign rd_addr_b = b_r[AW-1:0];
  assign src_sel   = src_r;
  assign wr_sel    = ~src_r;
  assign wr_addr   = k_r[AW-1:0];
  assign wr_data   = take_a ? rd_data_a : rd_data_b;
  assign status    = '{done: done_r, result_sel: sel_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MG_IDLE;
      a_r     <= '0;
      b_r     <= '0;
      k_r     <= '0;
      mid_r   <= '0;
      hi_r    <= '0;
      width_r <= '0;
      src_r   <= 1'b0;
      done_r  <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      k_r     <= k_nxt;
      mid_r   <= mid_nxt;
      hi_r    <= hi_nxt;
      width_r <= width_nxt;
      src_r   <= src_nxt;
      done_r  <= done_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    logic             setup;
    logic [CNT_W-1:0] set_lo, set_w;
    logic [SW-1:0]    sum_mid, sum_hi, w2;

    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    k_nxt     = k_r;
    mid_nxt   = mid_r;
    hi_nxt    = hi_r;
    width_nxt = width_r;
    src_nxt   = src_r;
    done_nxt  = 1'b0;
    sel_nxt   = sel_r;
    wr_en     = 1'b0;
    setup     = 1'b0;
    set_lo    = '0;
    set_w     = width_r;
    sum_mid   = '0;
    sum_hi    = '0;
    w2        = SW'(width_r) << 1;

    case (state_r)
      MG_IDLE: begin
        if (start) begin
          if (n <= CNT_W'(1)) begin
            // A single element is already sorted and sits in the first RAM.
            done_nxt = 1'b1;
            sel_nxt  = 1'b0;
          end else begin
            width_nxt = CNT_W'(1);
            src_nxt   = 1'b0;
            set_lo    = '0;
            set_w     = CNT_W'(1);
            setup     = 1'b1;
            state_nxt = MG_RD;
          end
        end
      end
      MG_RD: begin
        state_nxt = MG_WR;
      end
      MG_WR: begin
        wr_en     = 1'b1;
        state_nxt = MG_RD;
        if (take_a) begin
          a_nxt = a_r + CNT_W'(1);
        end else begin
          b_nxt = b_r + CNT_W'(1);
        end
        k_nxt = k_r + CNT_W'(1);
        if ((k_r + CNT_W'(1)) == hi_r) begin
          if (hi_r == n) begin
            // End of a pass over the whole set.
            if (w2 >= SW'(n)) begin
              done_nxt  = 1'b1;
              sel_nxt   = ~src_r;
              state_nxt = MG_IDLE;
            end else begin
              width_nxt = w2[CNT_W-1:0];
              src_nxt   = ~src_r;
              set_lo    = '0;
              set_w     = w2[CNT_W-1:0];
              setup     = 1'b1;
            end
          end else begin
            set_lo = hi_r;
            set_w  = width_r;
            setup  = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = MG_IDLE;
      end
    endcase

    if (setup) begin
      // A lone tail run gets an empty right run, so it is simply copied across.
      sum_mid = SW'(set_lo) + SW'(set_w);
      sum_hi  = sum_mid + SW'(set_w);
      mid_nxt = (sum_mid < SW'(n)) ? sum_mid[CNT_W-1:0] : n;
      hi_nxt  = (sum_hi < SW'(n)) ? sum_hi[CNT_W-1:0] : n;
      a_nxt   = set_lo;
      b_nxt   = mid_nxt;
      k_nxt   = set_lo;
    end
  end

endmodule

`default_nettype wire

>>> sv/bottom_up_merge_sort_engine_core.sv
// Top level of the bottom-up merge sort engine: load, sort and emit control.
//
// Input stream: in_tdata carries one signed value per transfer, in_tlast marks the
// final value of a set. Values are stored one per cycle while in_tready is high; a
// value that finds the store full (DEPTH entries) is dropped and flagged.
// After the transfer with in_tlast, in_tready drops while the set is sorted and sent.
// Sorting runs ceil(log2(n)) passes over the n stored values; in each pass every
// element goes through a read state and then a compare-and-write state, with the
// single comparator working between two two-read-port RAMs.
// Output stream: one transfer per sorted value, ascending, each read from the RAM;
// out_tlast marks the final value and out_tuser flags a set that lost items.
// When the receiver stalls, the output register holds its value and the engine waits.
// The engine takes the next set as soon as the final result sits in the output
// register. Synchronous active-low reset empties the store and clears all control
// state; stored values themselves are not cleared.
`default_nettype none

module bottom_up_merge_sort_engine_core import msort_pkg::*; #(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  localparam int TDATA_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // [DATA_WIDTH-1:0] value
  input  wire logic               in_tlast,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic      [TDATA_W-1:0] out_tdata,  // [DATA_WIDTH-1:0] sorted_value
  output logic                    out_tlast,
  output logic                    out_tuser   // [0] overflow
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  top_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt, emit_k_r, emit_k_nxt;
  logic                  dropped_r, dropped_nxt, start_r, start_nxt;
  logic                  result_sel_r, result_sel_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic                  out_last_r, out_ovf_r, out_load, emit_last;
  logic                  in_xfer, load_we, emitting;

  merge_status_t         mstat;
  logic [AW-1:0]         m_rd_a, m_rd_b, m_wr_addr, raddr_a;
  logic                  m_src_sel, m_wr_en, m_wr_sel;
  logic [DATA_WIDTH-1:0] m_wr_data, m_rd_data_a, m_rd_data_b, emit_data;
  logic                  we0, we1;
  logic [AW-1:0]         waddr0;
  logic [DATA_WIDTH-1:0] wdata0;
  logic [DATA_WIDTH-1:0] r0_a, r0_b, r1_a, r1_b;

  assign in_tready = (state_r == ST_LOAD);
  assign in_xfer   = in_tvalid && in_tready;
  assign load_we   = in_xfer && (count_r < CNT_W'(DEPTH));
  assign emitting  = (state_r == ST_EM_REQ) || (state_r == ST_EM_LOAD);

  // The first RAM takes loads and even-pass merge results; the second only merge results.
  assign we0    = load_we || (m_wr_en && !m_wr_sel);
  assign waddr0 = load_we ? count_r[AW-1:0] : m_wr_addr;
  assign wdata0 = load_we ? in_tdata[DATA_WIDTH-1:0] : m_wr_data;
  assign we1    = m_wr_en && m_wr_sel;

  assign raddr_a     = emitting ? emit_k_r[AW-1:0] : m_rd_a;
  assign m_rd_data_a = m_src_sel ? r1_a : r0_a;
  assign m_rd_data_b = m_src_sel ? r1_b : r0_b;
  assign emit_data   = result_sel_r ? r1_a : r0_a;

  msort_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a),
    .raddr_b (m_rd_b),
    .rdata_a (r0_a),
    .rdata_b (r0_b)
  );

  msort_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (m_wr_addr),
    .wdata   (m_wr_data),
    .raddr_a (raddr_a),
    .raddr_b (m_rd_b),
    .rdata_a (r1_a),
    .rdata_b (r1_b)
  );

  msort_merge #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .n         (count_r),
    .rd_addr_a (m_rd_a),
    .rd_addr_b (m_rd_b),
    .src_sel   (m_src_sel),
    .rd_data_a (m_rd_data_a),
    .rd_data_b (m_rd_data_b),
    .wr_en     (m_wr_en),
    .wr_sel    (m_wr_sel),
    .wr_addr   (m_wr_addr),
    .wr_data   (m_wr_data),
    .status    (mstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      count_r      <= '0;
      emit_k_r     <= '0;
      dropped_r    <= 1'b0;
      start_r      <= 1'b0;
      result_sel_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      emit_k_r     <= emit_k_nxt;
      dropped_r    <= dropped_nxt;
      start_r      <= start_nxt;
      result_sel_r <= result_sel_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= emit_data;
      out_last_r <= emit_last;
      out_ovf_r  <= dropped_r;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    emit_k_nxt     = emit_k_r;
    dropped_nxt    = dropped_r;
    start_nxt      = 1'b0;
    result_sel_nxt = result_sel_r;
    out_load       = 1'b0;
    emit_last      = (CNT_W'(emit_k_r + CNT_W'(1)) == count_r);

    case (state_r)
      ST_LOAD: begin
        if (in_xfer) begin
          if (load_we) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_tlast) begin
            start_nxt = 1'b1;
            state_nxt = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        if (mstat.done) begin
          result_sel_nxt = mstat.result_sel;
          emit_k_nxt     = '0;
          state_nxt      = ST_EM_REQ;
        end
      end
      ST_EM_REQ: begin
        // The read goes out now; the output register must be free when the data lands.
        if (!out_valid_r || out_tready) begin
          state_nxt = ST_EM_LOAD;
        end
      end
      ST_EM_LOAD: begin
        out_load = 1'b1;
        if (emit_last) begin
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end else begin
          emit_k_nxt = emit_k_r + CNT_W'(1);
          state_nxt  = ST_EM_REQ;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ovf_r;

endmodule

`default_nettype wire

>>> sv/msort_checker.sv
// Port-level checker for the merge sort engine, bound to the top level.
`default_nettype none

module msort_checker import msort_pkg::*; #(
  parameter int TDATA_W = TDATA_W_DEF
) (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               in_tlast,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [TDATA_W-1:0] out_tdata,
  input wire logic               out_tlast,
  input wire logic               out_tuser
);

  // Reset leaves no result pending.
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The engine stops taking input once a set is closed.
  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=> !in_tready)
    else $error("input accepted right after end of set");

  // No new set is taken while the current one is still being sent.
  a_no_load_mid_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> !in_tready)
    else $error("input ready in the middle of a sorted set");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind bottom_up_merge_sort_engine_core msort_checker u_msort_checker (.*);

`default_nettype wire
